FILE: design/hkc_pkg.sv
package hkc_pkg;

   localparam int unsigned TICK_WIDTH     = 8;
   localparam int unsigned SAVE_WIDTH     = 8;
   localparam int unsigned SECONDS_WIDTH  = 16;
   localparam int unsigned SETPOINT_WIDTH = 9;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned REQ_DATA_WIDTH = 8;
   localparam int unsigned RSP_DATA_WIDTH = 24;

   localparam logic [TICK_WIDTH-1:0]     TICK_DIVIDER_LIMIT_RESET = 8'd10;
   localparam logic [SAVE_WIDTH-1:0]     SAVE_DELAY_LIMIT_RESET   = 8'd50;
   localparam logic [SECONDS_WIDTH-1:0]  AUTO_OFF_LIMIT_RESET     = 16'd12000;
   localparam logic [SETPOINT_WIDTH-1:0] SETPOINT_MAX_RESET       = 9'd270;
   localparam logic [SETPOINT_WIDTH-1:0] SETPOINT_RESET           = 9'd0;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TICK_DIVIDER_LIMIT = 3'd0,
      CSR_SAVE_DELAY_LIMIT   = 3'd1,
      CSR_AUTO_OFF_LIMIT     = 3'd2,
      CSR_SETPOINT_MAX       = 3'd3,
      CSR_START_SETPOINT_A   = 3'd4,
      CSR_START_SETPOINT_B   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0]     tick_divider_limit;
      logic [SAVE_WIDTH-1:0]     save_delay_limit;
      logic [SECONDS_WIDTH-1:0]  auto_off_limit;
      logic [SETPOINT_WIDTH-1:0] setpoint_max;
   } cfg_type;

   typedef struct packed {
      logic save_clear;
      logic down_key;
      logic up_key;
      logic off_key;
      logic mode_key;
   } key_word_type;

   typedef struct packed {
      logic [SETPOINT_WIDTH-1:0] setpoint_b_out;
      logic [SETPOINT_WIDTH-1:0] setpoint_a_out;
      logic                      mode_b;
      logic                      save_request;
      logic                      run_enable;
      logic                      heat_enable;
      logic                      beeper;
   } result_type;

endpackage

FILE: design/hkc_csr.sv
module hkc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hkc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [hkc_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output hkc_pkg::cfg_type                     cfg
);
   import hkc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TICK_DIVIDER_LIMIT: cfg_in.tick_divider_limit = csr_data[TICK_WIDTH-1:0];
            CSR_SAVE_DELAY_LIMIT:   cfg_in.save_delay_limit   = csr_data[SAVE_WIDTH-1:0];
            CSR_AUTO_OFF_LIMIT:     cfg_in.auto_off_limit     = csr_data[SECONDS_WIDTH-1:0];
            CSR_SETPOINT_MAX:       cfg_in.setpoint_max       = csr_data[SETPOINT_WIDTH-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_divider_limit <= TICK_DIVIDER_LIMIT_RESET;
         cfg_ff.save_delay_limit   <= SAVE_DELAY_LIMIT_RESET;
         cfg_ff.auto_off_limit     <= AUTO_OFF_LIMIT_RESET;
         cfg_ff.setpoint_max       <= SETPOINT_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/hkc_core.sv
module hkc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  hkc_pkg::key_word_type item,
   input  hkc_pkg::cfg_type      cfg,
   output hkc_pkg::result_type   result
);
   import hkc_pkg::*;

   logic mode_reg_ff, mode_reg_in;
   logic [SETPOINT_WIDTH-1:0] setpoint_a_ff, setpoint_a_in;
   logic [SETPOINT_WIDTH-1:0] setpoint_b_ff, setpoint_b_in;
   logic mode_seen_ff, mode_seen_in, mode_armed_ff, mode_armed_in;
   logic off_seen_ff, off_seen_in;
   logic up_seen_ff, up_seen_in, up_armed_ff, up_armed_in;
   logic down_seen_ff, down_seen_in, down_armed_ff, down_armed_in;
   logic [TICK_WIDTH-1:0]    tick_count_ff, tick_count_in;
   logic [SECONDS_WIDTH-1:0] seconds_count_ff, seconds_count_in;
   logic                     save_timing_ff, save_timing_in;
   logic [SAVE_WIDTH-1:0]    save_count_ff, save_count_in;
   logic save_pending_ff, save_pending_in;
   logic beep_pending_ff, beep_pending_in;
   logic beep_done_ff, beep_done_in;
   logic beep_level_ff, beep_level_in;
   logic heat_flag_ff, heat_flag_in;
   logic run_flag_ff, run_flag_in;
   logic [SETPOINT_WIDTH:0]  sp_inc;
   logic [TICK_WIDTH:0]      tick_next;

   always_comb begin
      mode_reg_in      = mode_reg_ff;
      setpoint_a_in    = setpoint_a_ff;
      setpoint_b_in    = setpoint_b_ff;
      mode_seen_in     = mode_seen_ff;
      mode_armed_in    = mode_armed_ff;
      off_seen_in      = off_seen_ff;
      up_seen_in       = up_seen_ff;
      up_armed_in      = up_armed_ff;
      down_seen_in     = down_seen_ff;
      down_armed_in    = down_armed_ff;
      tick_count_in    = tick_count_ff;
      seconds_count_in = seconds_count_ff;
      save_timing_in   = save_timing_ff;
      save_count_in    = save_count_ff;
      save_pending_in  = save_pending_ff;
      beep_pending_in  = beep_pending_ff;
      beep_done_in     = beep_done_ff;
      beep_level_in    = beep_level_ff;
      heat_flag_in     = heat_flag_ff;
      run_flag_in      = run_flag_ff;
      sp_inc           = '0;
      tick_next        = {1'b0, tick_count_ff} + {{TICK_WIDTH{1'b0}}, 1'b1};

      if (item.save_clear) begin
         save_pending_in = 1'b0;
      end

      // mode key: toggle on release
      if (mode_armed_in && item.mode_key) begin
         mode_reg_in    = ~mode_reg_in;
         mode_armed_in  = 1'b0;
         mode_seen_in   = 1'b0;
         save_timing_in = 1'b1;
         save_count_in  = '0;
         beep_done_in   = 1'b0;
         run_flag_in    = 1'b1;
      end
      if (mode_seen_in && !item.mode_key) begin
         mode_armed_in = 1'b1;
         heat_flag_in  = 1'b1;
         if (!beep_done_in) begin
            beep_pending_in = 1'b1;
         end
      end
      if (!item.mode_key && !mode_seen_in) begin
         mode_seen_in = 1'b1;
      end

      // off key: act while held
      if (off_seen_in && !item.off_key) begin
         off_seen_in  = 1'b0;
         heat_flag_in = 1'b0;
         run_flag_in  = 1'b0;
      end
      if (!item.off_key && !off_seen_in) begin
         off_seen_in = 1'b1;
      end

      // up key: step and clamp at max
      if (up_armed_in && item.up_key) begin
         if (!mode_reg_in) begin
            sp_inc = {1'b0, setpoint_a_in} + {{SETPOINT_WIDTH{1'b0}}, 1'b1};
            setpoint_a_in = (sp_inc > {1'b0, cfg.setpoint_max}) ? cfg.setpoint_max
                                                                : sp_inc[SETPOINT_WIDTH-1:0];
         end else begin
            sp_inc = {1'b0, setpoint_b_in} + {{SETPOINT_WIDTH{1'b0}}, 1'b1};
            setpoint_b_in = (sp_inc > {1'b0, cfg.setpoint_max}) ? cfg.setpoint_max
                                                                : sp_inc[SETPOINT_WIDTH-1:0];
         end
         up_armed_in    = 1'b0;
         up_seen_in     = 1'b0;
         save_timing_in = 1'b1;
         save_count_in  = '0;
         beep_done_in   = 1'b0;
         run_flag_in    = 1'b1;
      end
      if (up_seen_in && !item.up_key) begin
         up_armed_in  = 1'b1;
         heat_flag_in = 1'b1;
         if (!beep_done_in) begin
            beep_pending_in = 1'b1;
         end
      end
      if (!item.up_key && !up_seen_in) begin
         up_seen_in = 1'b1;
      end

      // down key: step and hold at zero
      if (down_armed_in && item.down_key) begin
         if (!mode_reg_in) begin
            if (setpoint_a_in != '0) begin
               setpoint_a_in = setpoint_a_in - {{(SETPOINT_WIDTH-1){1'b0}}, 1'b1};
            end
         end else begin
            if (setpoint_b_in != '0) begin
               setpoint_b_in = setpoint_b_in - {{(SETPOINT_WIDTH-1){1'b0}}, 1'b1};
            end
         end
         down_armed_in  = 1'b0;
         down_seen_in   = 1'b0;
         save_timing_in = 1'b1;
         save_count_in  = '0;
         beep_done_in   = 1'b0;
         run_flag_in    = 1'b1;
      end
      if (down_seen_in && !item.down_key) begin
         down_armed_in = 1'b1;
         heat_flag_in  = 1'b1;
         if (!beep_done_in) begin
            beep_pending_in = 1'b1;
         end
      end
      if (!item.down_key && !down_seen_in) begin
         down_seen_in = 1'b1;
      end

      // tick divider and slow period
      if (tick_next > {1'b0, cfg.tick_divider_limit}) begin
         tick_count_in    = '0;
         seconds_count_in = seconds_count_ff + {{(SECONDS_WIDTH-1){1'b0}}, 1'b1};
         if (save_timing_in) begin
            save_count_in = save_count_in + {{(SAVE_WIDTH-1){1'b0}}, 1'b1};
            if (save_count_in > cfg.save_delay_limit) begin
               save_pending_in = 1'b1;
               save_count_in   = '0;
               save_timing_in  = 1'b0;
            end
         end
         if (seconds_count_in > cfg.auto_off_limit) begin
            if (!mode_reg_in) begin
               run_flag_in = 1'b0;
            end
            seconds_count_in = '0;
         end
         if (!beep_pending_in) begin
            beep_level_in = 1'b0;
         end else begin
            beep_level_in   = 1'b1;
            beep_pending_in = 1'b0;
            beep_done_in    = 1'b1;
         end
      end else begin
         tick_count_in = tick_next[TICK_WIDTH-1:0];
      end
   end

   assign result.beeper         = beep_level_in;
   assign result.heat_enable    = heat_flag_in;
   assign result.run_enable     = run_flag_in;
   assign result.save_request   = save_pending_in;
   assign result.mode_b         = mode_reg_in;
   assign result.setpoint_a_out = setpoint_a_in;
   assign result.setpoint_b_out = setpoint_b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_reg_ff      <= 1'b0;
         setpoint_a_ff    <= SETPOINT_RESET;
         setpoint_b_ff    <= SETPOINT_RESET;
         mode_seen_ff     <= 1'b0;
         mode_armed_ff    <= 1'b0;
         off_seen_ff      <= 1'b0;
         up_seen_ff       <= 1'b0;
         up_armed_ff      <= 1'b0;
         down_seen_ff     <= 1'b0;
         down_armed_ff    <= 1'b0;
         tick_count_ff    <= '0;
         seconds_count_ff <= '0;
         save_timing_ff   <= 1'b0;
         save_count_ff    <= '0;
         save_pending_ff  <= 1'b0;
         beep_pending_ff  <= 1'b0;
         beep_done_ff     <= 1'b0;
         beep_level_ff    <= 1'b0;
         heat_flag_ff     <= 1'b0;
         run_flag_ff      <= 1'b1;
      end else if (fire) begin
         mode_reg_ff      <= mode_reg_in;
         setpoint_a_ff    <= setpoint_a_in;
         setpoint_b_ff    <= setpoint_b_in;
         mode_seen_ff     <= mode_seen_in;
         mode_armed_ff    <= mode_armed_in;
         off_seen_ff      <= off_seen_in;
         up_seen_ff       <= up_seen_in;
         up_armed_ff      <= up_armed_in;
         down_seen_ff     <= down_seen_in;
         down_armed_ff    <= down_armed_in;
         tick_count_ff    <= tick_count_in;
         seconds_count_ff <= seconds_count_in;
         save_timing_ff   <= save_timing_in;
         save_count_ff    <= save_count_in;
         save_pending_ff  <= save_pending_in;
         beep_pending_ff  <= beep_pending_in;
         beep_done_ff     <= beep_done_in;
         beep_level_ff    <= beep_level_in;
         heat_flag_ff     <= heat_flag_in;
         run_flag_ff      <= run_flag_in;
      end
   end

endmodule

FILE: design/heater_panel_key_controller.sv
// Heater panel key controller. Each request word is one timer tick with the
// four active-low key levels and a save-clear flag; each tick yields exactly
// one response word with the beeper, heat, run, save-request and mode flags
// and both setpoints as they stand after that tick. A word is taken every
// clock cycle unless a held response stalls; it passes the input register,
// then key and divider logic into the output register. The user is to
// write the limits through the csr port only while no tick is in flight;
// the block does not enforce it. Both setpoints start at zero after reset;
// the start-setpoint registers are accepted but do not change the outputs.
module heater_panel_key_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] mode_key, [1] off_key, [2] up_key, [3] down_key, [4] save_clear
   input  logic [hkc_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] beeper, [1] heat_enable, [2] run_enable, [3] save_request,
   // [4] mode_b, [13:5] setpoint_a_out, [22:14] setpoint_b_out
   output logic [hkc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hkc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [hkc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import hkc_pkg::*;

   logic         in_valid_ff;
   key_word_type in_word_ff;
   logic         out_valid_ff;
   result_type   out_word_ff;
   logic         out_free;
   logic         fire;
   cfg_type      cfg;
   result_type   result;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - $bits(result_type)){1'b0}}, out_word_ff};

   hkc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hkc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_word_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff <= req_tdata[$bits(key_word_type)-1:0];
      end
      if (fire) begin
         out_word_ff <= result;
      end
   end

endmodule

FILE: design/hkc_checker.sv
module hkc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [hkc_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input logic                                 csr_valid,
   input logic                                 csr_ready
);
   import hkc_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response word valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid |-> rsp_tdata[RSP_DATA_WIDTH-1] == 1'b0)
      else $error("response pad bit set");

   assert property (@(posedge clock) disable iff (reset) csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind heater_panel_key_controller hkc_checker u_hkc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
